### design/rsc_pkg.sv
package rsc_pkg;

	localparam int OBJ_W = 32;
	localparam int CNT_W = 16;
	localparam int SLOT_OUT_W = 6;
	localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;

	typedef enum logic [1:0] {
		CMD_GET  = 2'd0,
		CMD_REF  = 2'd1,
		CMD_PUT  = 2'd2,
		CMD_PEEK = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_NEW      = 3'd1,
		ST_FULL     = 3'd2,
		ST_RANGE    = 3'd3,
		ST_NOT_LIVE = 3'd4,
		ST_OVERFLOW = 3'd5
	} status_t;

	// command held steady on every cell while a scan runs
	typedef struct packed {
		cmd_t             cmd;
		logic [OBJ_W-1:0] num;
	} cmd_bus_t;

	// scan token handed from cell to cell
	typedef struct packed {
		logic             valid;
		logic             hit;
		logic             free;
		logic [CNT_W-1:0] count;
	} tok_t;

	// write-back into the one addressed cell
	typedef struct packed {
		logic             en;
		logic             set_obj;
		logic [OBJ_W-1:0] obj;
		logic [CNT_W-1:0] count;
	} wb_t;

endpackage

### design/rsc_cell.sv
module rsc_cell #(
	parameter int IDX_W = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [IDX_W-1:0]      my_index,
	input  rsc_pkg::cmd_bus_t     cmd_bus,
	input  logic [IDX_W-1:0]      target,
	input  rsc_pkg::tok_t         tok_in,
	input  logic [IDX_W-1:0]      hit_idx_in,
	input  logic [IDX_W-1:0]      free_idx_in,
	output rsc_pkg::tok_t         tok_out,
	output logic [IDX_W-1:0]      hit_idx_out,
	output logic [IDX_W-1:0]      free_idx_out,
	input  rsc_pkg::wb_t          wb,
	input  logic [IDX_W-1:0]      wr_index
);

	logic [rsc_pkg::OBJ_W-1:0] obj_q;
	logic [rsc_pkg::CNT_W-1:0] cnt_q;
	rsc_pkg::tok_t             tok_q;
	logic [IDX_W-1:0]          hit_idx_q;
	logic [IDX_W-1:0]          free_idx_q;

	rsc_pkg::tok_t             tok_n;
	logic [IDX_W-1:0]          hit_idx_n;
	logic [IDX_W-1:0]          free_idx_n;
	logic                      live;

	assign live = (cnt_q != '0);

	always_comb begin
		tok_n      = tok_in;
		hit_idx_n  = hit_idx_in;
		free_idx_n = free_idx_in;
		if (tok_in.valid) begin
			case (cmd_bus.cmd)
				rsc_pkg::CMD_GET: begin
					if (!tok_in.hit && live && obj_q == cmd_bus.num) begin
						tok_n.hit   = 1'b1;
						tok_n.count = cnt_q;
						hit_idx_n   = my_index;
					end else if (!tok_in.free && !live) begin
						// remember the lowest free slot on the way
						tok_n.free = 1'b1;
						free_idx_n = my_index;
					end
				end
				default: begin
					if (my_index == target) begin
						tok_n.hit   = 1'b1;
						tok_n.count = cnt_q;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
			cnt_q <= '0;
			obj_q <= '0;
		end else begin
			tok_q <= tok_n;
			if (wb.en && wr_index == my_index) begin
				cnt_q <= wb.count;
				if (wb.set_obj) begin
					obj_q <= wb.obj;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		hit_idx_q  <= hit_idx_n;
		free_idx_q <= free_idx_n;
	end

	assign tok_out      = tok_q;
	assign hit_idx_out  = hit_idx_q;
	assign free_idx_out = free_idx_q;

endmodule

### design/refcounted_inode_slot_cache_unit.sv
// Reference-counted slot cache: a row of slot cells, each holding an object
// number and a 16-bit count; a slot is live while its count is nonzero.
// Command channel: cmd, object_number, slot_index are taken when start is
// high and busy is low. cmd get looks up or claims a slot for object_number,
// ref and put add or drop a reference on slot_index, peek reads a count.
// Result channel: slot, status, ref_count, released are valid for exactly
// one cycle while done is high; the receiver cannot stall, so nothing waits.
// Config channel: cfg_data is written to the object limit when cfg_valid
// and cfg_ready are both high; write it only while the block is idle.
// Answers: a get with a number at or above the limit, and a ref, put or peek
// on a slot beyond the table, answer in the cycle after acceptance. Every
// other command sends a token down the cell row, one cell per cycle, and
// answers once the token has left the last cell. busy drops in the cycle
// where done rises, so a new command can be taken then.
// Reset: every slot is free, the object limit is all ones, no command runs.
module refcounted_inode_slot_cache_unit #(
	parameter int NUM_SLOTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  cmd,
	input  logic [31:0] object_number,
	input  logic [5:0]  slot_index,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	output logic        done,
	output logic [5:0]  slot,
	output logic [2:0]  status,
	output logic [15:0] ref_count,
	output logic        released
);

	localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int AW    = ((IDX_W > rsc_pkg::SLOT_OUT_W) ? IDX_W : rsc_pkg::SLOT_OUT_W) + 1;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_SCAN = 2'b10
	} state_t;

	state_t                    state_q;
	logic                      inj_q;
	logic [31:0]               limit_q;
	rsc_pkg::cmd_t             cmd_q;
	logic [31:0]               num_q;
	logic [5:0]                idx_q;

	logic                      done_q;
	logic [5:0]                slot_q;
	rsc_pkg::status_t          status_q;
	logic [15:0]               count_q;
	logic                      released_q;

	rsc_pkg::tok_t             tok_chain  [NUM_SLOTS+1];
	logic [IDX_W-1:0]          hidx_chain [NUM_SLOTS+1];
	logic [IDX_W-1:0]          fidx_chain [NUM_SLOTS+1];

	rsc_pkg::cmd_bus_t         cmd_bus;
	logic [IDX_W-1:0]          target;
	logic [AW-1:0]             idx_ext;
	rsc_pkg::wb_t              wb;
	logic [IDX_W-1:0]          wr_index;

	rsc_pkg::tok_t             tail;
	rsc_pkg::cmd_t             cmd_in;
	logic                      accept;
	logic                      early;
	logic [5:0]                e_slot;
	rsc_pkg::status_t          e_status;
	logic [5:0]                t_slot;
	rsc_pkg::status_t          t_status;
	logic [15:0]               t_count;
	logic                      t_released;

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = !busy;
	assign accept    = start && !busy;
	assign cmd_in    = rsc_pkg::cmd_t'(cmd);

	// answer out-of-range commands without a scan
	always_comb begin
		early    = 1'b0;
		e_slot   = slot_index;
		e_status = rsc_pkg::ST_OK;
		if (cmd_in == rsc_pkg::CMD_GET) begin
			if (object_number >= limit_q) begin
				early    = 1'b1;
				e_slot   = '0;
				e_status = rsc_pkg::ST_RANGE;
			end
		end else if (AW'(slot_index) >= AW'(NUM_SLOTS)) begin
			early    = 1'b1;
			e_status = (cmd_in == rsc_pkg::CMD_PEEK) ? rsc_pkg::ST_OK
			                                         : rsc_pkg::ST_NOT_LIVE;
		end
	end

	assign cmd_bus.cmd = cmd_q;
	assign cmd_bus.num = num_q;
	assign idx_ext     = AW'(idx_q);
	assign target      = idx_ext[IDX_W-1:0];

	assign tok_chain[0]  = '{valid: inj_q, hit: 1'b0, free: 1'b0, count: '0};
	assign hidx_chain[0] = '0;
	assign fidx_chain[0] = '0;

	for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
		rsc_cell #(
			.IDX_W(IDX_W)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.my_index    (IDX_W'(i)),
			.cmd_bus     (cmd_bus),
			.target      (target),
			.tok_in      (tok_chain[i]),
			.hit_idx_in  (hidx_chain[i]),
			.free_idx_in (fidx_chain[i]),
			.tok_out     (tok_chain[i+1]),
			.hit_idx_out (hidx_chain[i+1]),
			.free_idx_out(fidx_chain[i+1]),
			.wb          (wb),
			.wr_index    (wr_index)
		);
	end

	assign tail = tok_chain[NUM_SLOTS];

	// settle the command once the token leaves the last cell
	always_comb begin
		wb         = '0;
		wr_index   = target;
		t_slot     = idx_q;
		t_status   = rsc_pkg::ST_OK;
		t_count    = tail.count;
		t_released = 1'b0;
		case (cmd_q)
			rsc_pkg::CMD_GET: begin
				if (tail.hit) begin
					t_slot   = 6'(hidx_chain[NUM_SLOTS]);
					wr_index = hidx_chain[NUM_SLOTS];
					if (tail.count == rsc_pkg::COUNT_MAX) begin
						t_status = rsc_pkg::ST_OVERFLOW;
					end else begin
						t_count  = tail.count + 16'd1;
						wb.en    = tail.valid;
						wb.count = tail.count + 16'd1;
					end
				end else if (tail.free) begin
					t_slot     = 6'(fidx_chain[NUM_SLOTS]);
					t_status   = rsc_pkg::ST_NEW;
					t_count    = 16'd1;
					wr_index   = fidx_chain[NUM_SLOTS];
					wb.en      = tail.valid;
					wb.set_obj = 1'b1;
					wb.obj     = num_q;
					wb.count   = 16'd1;
				end else begin
					t_slot   = '0;
					t_status = rsc_pkg::ST_FULL;
					t_count  = '0;
				end
			end
			rsc_pkg::CMD_REF: begin
				if (tail.count == '0) begin
					t_status = rsc_pkg::ST_NOT_LIVE;
				end else if (tail.count == rsc_pkg::COUNT_MAX) begin
					t_status = rsc_pkg::ST_OVERFLOW;
				end else begin
					t_count  = tail.count + 16'd1;
					wb.en    = tail.valid;
					wb.count = tail.count + 16'd1;
				end
			end
			rsc_pkg::CMD_PUT: begin
				if (tail.count == '0) begin
					t_status = rsc_pkg::ST_NOT_LIVE;
				end else begin
					t_count    = tail.count - 16'd1;
					t_released = (tail.count == 16'd1);
					wb.en      = tail.valid;
					wb.count   = tail.count - 16'd1;
				end
			end
			default: begin
				t_status = rsc_pkg::ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			inj_q   <= 1'b0;
			done_q  <= 1'b0;
			limit_q <= 32'hFFFF_FFFF;
		end else begin
			inj_q  <= 1'b0;
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				limit_q <= cfg_data;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (early) begin
							done_q <= 1'b1;
						end else begin
							inj_q   <= 1'b1;
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (tail.valid) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd_in;
			num_q <= object_number;
			idx_q <= slot_index;
		end
		if (accept && early) begin
			slot_q     <= e_slot;
			status_q   <= e_status;
			count_q    <= '0;
			released_q <= 1'b0;
		end else if (tail.valid) begin
			slot_q     <= t_slot;
			status_q   <= t_status;
			count_q    <= t_count;
			released_q <= t_released;
		end
	end

	assign done      = done_q;
	assign slot      = slot_q;
	assign status    = status_q;
	assign ref_count = count_q;
	assign released  = released_q;

	a_token_enters: assert property (@(posedge clk) disable iff (!arst_n)
		inj_q |=> tok_chain[1].valid)
		else $error("scan token did not enter the first cell");

	a_tail_answers: assert property (@(posedge clk) disable iff (!arst_n)
		tail.valid |=> (done_q && state_q == S_IDLE))
		else $error("token left the row without a result");

	a_quiet_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> !done_q)
		else $error("result strobe during a scan");

	a_release_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && released_q) |-> (status_q == rsc_pkg::ST_OK && count_q == '0))
		else $error("release flagged with a nonzero count");

endmodule
